/* rtl/ffpa_pkg.sv */
// shared types and constants of the frame pool allocator
package ffpa_pkg;

    // field widths
    localparam int OP_W       = 1;
    localparam int ADDR_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int FADDR_W    = 26;
    localparam int FIDX_W     = 10;
    localparam int FFREE_W    = 11;
    localparam int CTR_W      = 32;
    localparam int FC_W       = 11;
    localparam int FB_W       = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC   = 1'b0;
    localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BYTES = 1'b1;

    // register reset values and limits
    localparam int              FC_RESET = 1024;
    localparam logic [FB_W-1:0] FB_RESET = 17'd2048;
    localparam logic [FB_W-1:0] FB_MAX   = 17'h10000;

    // low-water mark is a quarter of the pool
    localparam int LOW_WATER_SHIFT = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOT_HELD = 2'd3
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [FADDR_W-1:0]   frame_address;
        logic [FIDX_W-1:0]    frame_index;
        logic [FFREE_W-1:0]   free_frames;
        logic                 low_water;
        logic [CTR_W-1:0]     failure_total;
        logic [CTR_W-1:0]     alloc_total;
        logic [CTR_W-1:0]     release_total;
    } t_result;

endpackage

/* rtl/ffpa_in_if.sv */
// request channel of the frame pool allocator
interface ffpa_in_if import ffpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] release_address;

    modport source (output valid, output operation, output release_address, input ready);
    modport sink   (input valid, input operation, input release_address, output ready);
endinterface

/* rtl/ffpa_out_if.sv */
// result channel of the frame pool allocator
interface ffpa_out_if import ffpa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FADDR_W-1:0]  frame_address;
    logic [FIDX_W-1:0]   frame_index;
    logic [FFREE_W-1:0]  free_frames;
    logic                low_water;
    logic [CTR_W-1:0]    failure_total;
    logic [CTR_W-1:0]    alloc_total;
    logic [CTR_W-1:0]    release_total;

    modport source (
        output valid, output status, output frame_address, output frame_index,
        output free_frames, output low_water, output failure_total,
        output alloc_total, output release_total, input ready
    );
    modport sink (
        input valid, input status, input frame_address, input frame_index,
        input free_frames, input low_water, input failure_total,
        input alloc_total, input release_total, output ready
    );
endinterface

/* rtl/ffpa_div.sv */
// bit-serial restoring divider: address by frame size, one quotient bit per cycle
module ffpa_div import ffpa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ADDR_W-1:0] i_dividend,
    input  logic [FB_W-1:0]   i_divisor,
    output logic              o_done,
    output logic [ADDR_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(ADDR_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_quo, n_quo;
    logic [FB_W-1:0]   r_rem, n_rem;
    logic [FB_W-1:0]   r_dvs, n_dvs;

    logic [FB_W:0]     trial;
    logic [FB_W:0]     diff;
    logic              fits;

    assign trial = {r_rem, r_quo[ADDR_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = STEP_W'(ADDR_W);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = fits ? diff[FB_W-1:0] : trial[FB_W-1:0];
            n_quo = {r_quo[ADDR_W-2:0], fits};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/ffpa_mul.sv */
// bit-serial shift-add multiplier: frame index times frame size, msb first
module ffpa_mul import ffpa_pkg::*; #(
    parameter int MPLR_W = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MPLR_W-1:0]  i_multiplier,
    input  logic [FB_W-1:0]    i_multiplicand,
    output logic               o_done,
    output logic [FADDR_W-1:0] o_product
);

    localparam int STEP_W = $clog2(MPLR_W + 1);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [STEP_W-1:0]  r_cnt, n_cnt;
    logic [MPLR_W-1:0]  r_mplr, n_mplr;
    logic [FB_W-1:0]    r_mcand, n_mcand;
    logic [FADDR_W-1:0] r_acc, n_acc;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_mplr  = r_mplr;
        n_mcand = r_mcand;
        n_acc   = r_acc;
        if (i_start) begin
            n_busy  = 1'b1;
            n_cnt   = STEP_W'(MPLR_W);
            n_mplr  = i_multiplier;
            n_mcand = i_multiplicand;
            n_acc   = '0;
        end else if (r_busy) begin
            // product kept modulo the address field width
            n_acc  = {r_acc[FADDR_W-2:0], 1'b0}
                   + (r_mplr[MPLR_W-1] ? FADDR_W'(r_mcand) : FADDR_W'(0));
            n_mplr = r_mplr << 1;
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mplr  <= n_mplr;
        r_mcand <= n_mcand;
        r_acc   <= n_acc;
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

/* rtl/fixed_frame_pool_allocator_core.sv */
// top level of the fixed frame pool allocator
// Hands out equal-sized frames from a pool of frame_count frames kept in a
// circular free list in block memory, one held bit per frame in a second memory.
// One request is worked at a time; a finished result sits in an output register,
// so the next request is taken while that result waits. An allocate reads the
// head of the free list and then waits on the bit-serial multiplier that forms
// index times frame size. A release waits on the 32-step bit-serial divider that
// turns the address into a frame index, then on one held-bit memory read. An
// allocate from an empty pool goes straight to completion. After reset and after
// every write of frame_count all MAX_FRAMES held bits are swept clear, one per
// cycle; no request is taken during the sweep, register writes are. Entries of
// the free list not yet rewritten since the last rebuild read as their own index,
// tracked by a fill count. Registers may only be written while the block is idle.
module fixed_frame_pool_allocator_core import ffpa_pkg::*; #(
    parameter int MAX_FRAMES = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ffpa_in_if.sink               i_in,
    ffpa_out_if.source            o_out
);

    localparam int IDX_W = $clog2(MAX_FRAMES);
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam logic [CNT_W-1:0] N_RST =
        CNT_W'((MAX_FRAMES < FC_RESET) ? MAX_FRAMES : FC_RESET);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RING  = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_HELD  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    // control state
    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_clr, n_clr;
    logic [CNT_W-1:0] r_n, n_n;
    logic [FB_W-1:0]  r_b, n_b;
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_free, n_free;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [CTR_W-1:0] r_fail, n_fail;
    logic [CTR_W-1:0] r_alloc, n_alloc;
    logic [CTR_W-1:0] r_rel, n_rel;
    logic             r_out_valid, n_out_valid;

    // per-request working registers
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [FADDR_W-1:0] r_addr, n_addr;
    t_status            r_status, n_status;
    logic               r_hit, n_hit;
    t_result            r_out, n_out;

    // memories
    logic [IDX_W-1:0] r_ring_mem [MAX_FRAMES];
    logic             r_held_mem [MAX_FRAMES];
    logic [IDX_W-1:0] r_ring_q;
    logic             r_held_q;

    logic             accept_in;
    logic             out_free;
    logic [CNT_W-1:0] head_inc, tail_inc;
    logic [IDX_W-1:0] head_next, tail_next;
    logic [IDX_W-1:0] ring_idx;
    logic [FC_W-1:0]  cfg_fc;
    logic [CNT_W-1:0] cfg_n;
    logic [FB_W-1:0]  cfg_b;

    logic              ring_we;
    logic              held_we;
    logic [IDX_W-1:0]  held_wa;
    logic              held_wd;
    logic [IDX_W-1:0]  held_ra;

    logic               mul_start, mul_done;
    logic [FADDR_W-1:0] mul_prod;
    logic               div_start, div_done;
    logic [ADDR_W-1:0]  div_quo;

    assign accept_in = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // ring pointers wrap at the pool size
    assign head_inc  = CNT_W'(r_head) + CNT_W'(1);
    assign tail_inc  = CNT_W'(r_tail) + CNT_W'(1);
    assign head_next = (head_inc >= r_n) ? '0 : IDX_W'(head_inc);
    assign tail_next = (tail_inc >= r_n) ? '0 : IDX_W'(tail_inc);

    // an entry never pushed since the rebuild still holds its own index
    assign ring_idx = r_hit ? r_ring_q : r_head;

    // register value clamping
    assign cfg_fc = i_cfg_data[FC_W-1:0];
    always_comb begin
        if (cfg_fc == '0) begin
            cfg_n = CNT_W'(1);
        end else if (32'(cfg_fc) > 32'(MAX_FRAMES)) begin
            cfg_n = CNT_W'(MAX_FRAMES);
        end else begin
            cfg_n = CNT_W'(cfg_fc);
        end
        if (i_cfg_data[FB_W-1:0] == '0) begin
            cfg_b = FB_W'(1);
        end else if (i_cfg_data[FB_W-1:0] > FB_MAX) begin
            cfg_b = FB_MAX;
        end else begin
            cfg_b = i_cfg_data[FB_W-1:0];
        end
    end

    // serial arithmetic units
    assign mul_start = (r_state == S_RING);
    assign div_start = accept_in && (i_in.operation == OP_RELEASE);

    ffpa_mul #(
        .MPLR_W (IDX_W)
    ) u_mul (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (mul_start),
        .i_multiplier   (ring_idx),
        .i_multiplicand (r_b),
        .o_done         (mul_done),
        .o_product      (mul_prod)
    );

    ffpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_in.release_address),
        .i_divisor  (r_b),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // held-bit port: clearing sweep, set on allocate, clear on release
    always_comb begin
        held_we = 1'b0;
        held_wa = r_idx;
        held_wd = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                held_we = 1'b1;
                held_wa = r_clr;
            end
            S_RING: begin
                held_we = 1'b1;
                held_wa = ring_idx;
                held_wd = 1'b1;
            end
            S_HELD: begin
                held_we = r_held_q;
            end
            default: begin
                held_we = 1'b0;
            end
        endcase
    end

    // look up the held bit of the quotient as it comes out of the divider
    assign held_ra = (r_state == S_DIV) ? IDX_W'(div_quo) : r_idx;

    // push the released index at the tail
    assign ring_we = (r_state == S_HELD) && r_held_q;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_n         = r_n;
        n_b         = r_b;
        n_head      = r_head;
        n_tail      = r_tail;
        n_free      = r_free;
        n_fill      = r_fill;
        n_fail      = r_fail;
        n_alloc     = r_alloc;
        n_rel       = r_rel;
        n_idx       = r_idx;
        n_addr      = r_addr;
        n_status    = r_status;
        n_hit       = r_hit;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;

        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == IDX_W'(MAX_FRAMES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept_in) begin
                    n_addr = '0;
                    if (i_in.operation == OP_ALLOC) begin
                        if (r_free == '0) begin
                            // empty pool: count the failure, list untouched
                            n_status = ST_EMPTY;
                            n_idx    = '0;
                            n_fail   = r_fail + 1'b1;
                            n_state  = S_DONE;
                        end else begin
                            n_hit   = (CNT_W'(r_head) < r_fill);
                            n_state = S_RING;
                        end
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_RING: begin
                // ring read data is back: pop the head
                n_idx   = ring_idx;
                n_head  = head_next;
                n_free  = r_free - 1'b1;
                n_alloc = r_alloc + 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                if (mul_done) begin
                    n_addr   = mul_prod;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (div_quo >= 32'(r_n)) begin
                        n_status = ST_RANGE;
                        n_idx    = '0;
                        n_state  = S_DONE;
                    end else begin
                        n_idx   = IDX_W'(div_quo);
                        n_state = S_HELD;
                    end
                end
            end
            S_HELD: begin
                n_state = S_DONE;
                if (!r_held_q) begin
                    n_status = ST_NOT_HELD;
                end else begin
                    n_status = ST_OK;
                    n_tail   = tail_next;
                    n_free   = r_free + 1'b1;
                    n_rel    = r_rel + 1'b1;
                    if (r_fill < r_n) begin
                        n_fill = r_fill + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out.status        = r_status;
                    n_out.frame_address = r_addr;
                    n_out.frame_index   = FIDX_W'(r_idx);
                    n_out.free_frames   = FFREE_W'(r_free);
                    n_out.low_water     = (r_free < (r_n >> LOW_WATER_SHIFT));
                    n_out.failure_total = r_fail;
                    n_out.alloc_total   = r_alloc;
                    n_out.release_total = r_rel;
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase

        // register writes; a new frame count rebuilds the pool, counters kept
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_COUNT: begin
                    n_n     = cfg_n;
                    n_head  = '0;
                    n_tail  = IDX_W'(cfg_n - 1'b1);
                    n_free  = cfg_n;
                    n_fill  = '0;
                    n_clr   = '0;
                    n_state = S_CLEAR;
                end
                CFG_FRAME_BYTES: begin
                    n_b = cfg_b;
                end
                default: begin
                    n_b = r_b;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_n         <= N_RST;
            r_b         <= FB_RESET;
            r_head      <= '0;
            r_tail      <= IDX_W'(N_RST - 1'b1);
            r_free      <= N_RST;
            r_fill      <= '0;
            r_fail      <= '0;
            r_alloc     <= '0;
            r_rel       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_n         <= n_n;
            r_b         <= n_b;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_free      <= n_free;
            r_fill      <= n_fill;
            r_fail      <= n_fail;
            r_alloc     <= n_alloc;
            r_rel       <= n_rel;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_addr   <= n_addr;
        r_status <= n_status;
        r_hit    <= n_hit;
        r_out    <= n_out;
    end

    // free list memory
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring_mem[tail_next] <= r_idx;
        end
        r_ring_q <= r_ring_mem[r_head];
    end

    // held-bit memory
    always_ff @(posedge i_clk) begin
        if (held_we) begin
            r_held_mem[held_wa] <= held_wd;
        end
        r_held_q <= r_held_mem[held_ra];
    end

    // result beat
    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out.status;
    assign o_out.frame_address = r_out.frame_address;
    assign o_out.frame_index   = r_out.frame_index;
    assign o_out.free_frames   = r_out.free_frames;
    assign o_out.low_water     = r_out.low_water;
    assign o_out.failure_total = r_out.failure_total;
    assign o_out.alloc_total   = r_out.alloc_total;
    assign o_out.release_total = r_out.release_total;

    // free count never exceeds the pool
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= r_n)
        else $error("free count above pool size");

    // fill count never exceeds the pool
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_n)
        else $error("fill count above pool size");

    // a release push only happens while some frame is out
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_we |-> (r_free < r_n))
        else $error("push into a full free list");

    // a result beat appears only out of the completion state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result beat raised outside completion");

endmodule
